// File: sv/brfvw_pkg.sv
// Shared types and constants for the variable-width bit ring FIFO.
// Holds request codes, field widths and the controller-to-datapath command.
// No dependencies.
`default_nettype none

package brfvw_pkg;

  // Fixed field widths of the request and result beats
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int FILL_W  = 6;
  localparam int REQ_W   = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_MSB = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_LSB = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_MSB  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_LSB  = 2'd3;

  // Command from the controller to the datapath
  typedef struct packed {
    logic load;       // a request beat is taken this cycle
    logic pop;        // request removes bits (else appends)
    logic msb_first;  // first bit maps to the most significant end
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/brfvw_ctrl.sv
// Controller of the variable-width bit ring FIFO: result slot state and request decode.
// Depends on brfvw_pkg.
`default_nettype none

module brfvw_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [brfvw_pkg::REQ_W-1:0] in_req_type,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output brfvw_pkg::cmd_t                cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic take;

  // Take a new beat when the result slot is free or drains this cycle
  assign in_ready  = (state_r == ST_IDLE) || out_ready;
  assign out_valid = (state_r == ST_HOLD);
  assign take      = in_valid && in_ready;

  // Advance the result slot state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (take) state_nxt = ST_HOLD;
        else if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode the request type into datapath commands
  always_comb begin
    cmd.load      = take;
    cmd.pop       = 1'b0;
    cmd.msb_first = 1'b0;
    unique case (in_req_type)
      brfvw_pkg::REQ_PUSH_MSB: begin
        cmd.msb_first = 1'b1;
      end
      brfvw_pkg::REQ_PUSH_LSB: begin
        cmd.msb_first = 1'b0;
      end
      brfvw_pkg::REQ_POP_MSB: begin
        cmd.pop       = 1'b1;
        cmd.msb_first = 1'b1;
      end
      brfvw_pkg::REQ_POP_LSB: begin
        cmd.pop       = 1'b1;
      end
      default: begin
        cmd.pop       = 1'b0;
      end
    endcase
  end

  // A result that is not taken stays offered
  a_hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // No beat is taken while a stalled result occupies the slot
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !cmd.load)
    else $error("request taken while result stalled");

  // Taking a beat always offers a result next cycle
  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("request taken without a result");

endmodule

`default_nettype wire

// File: sv/brfvw_dp.sv
// Datapath of the variable-width bit ring FIFO: bit ring, pointers, funnel
// gather and scatter, popped value registers and fill level. Depends on brfvw_pkg.
`default_nettype none

module brfvw_dp #(
  parameter int RING_BITS      = 64,
  parameter int MAX_FIELD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire brfvw_pkg::cmd_t               cmd,
  input  wire logic [brfvw_pkg::VALUE_W-1:0] push_value,
  input  wire logic [brfvw_pkg::COUNT_W-1:0] bit_count,
  output logic      [brfvw_pkg::VALUE_W-1:0] popped_value,
  output logic      [brfvw_pkg::VALUE_W-1:0] previous_value,
  output logic      [brfvw_pkg::FILL_W-1:0]  fill_level
);

  localparam int VW    = brfvw_pkg::VALUE_W;
  localparam int CW    = brfvw_pkg::COUNT_W;
  localparam int PW    = $clog2(RING_BITS);
  localparam int SW    = PW + CW + 1;
  localparam int WRAPS = (MAX_FIELD_BITS + RING_BITS - 1) / RING_BITS;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FIELD_BITS);
  localparam logic [SW-1:0] RING_S  = SW'(RING_BITS);

  logic [RING_BITS-1:0] ring_r, ring_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [VW-1:0]        last_r, last_nxt;
  logic [VW-1:0]        prior_r, prior_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;

  logic [CW-1:0]        cnt;
  logic [PW-1:0]        base;
  logic [PW-1:0]        idx [MAX_FIELD_BITS];
  logic [VW-1:0]        raw;
  logic [VW-1:0]        raw_rev;
  logic [VW-1:0]        mask;
  logic [VW-1:0]        pop_val;
  logic [VW-1:0]        src_shl;
  logic [VW-1:0]        src_msb;
  logic [VW-1:0]        src;
  logic [PW:0]          diff;

  // Fold a pointer sum back into the ring
  function automatic logic [PW-1:0] wrap_ptr(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = s;
    for (int w = 0; w < WRAPS; w++) begin
      if (t >= RING_S) t = t - RING_S;
    end
    return t[PW-1:0];
  endfunction

  // Saturate the count to the widest field
  assign cnt  = (bit_count > MAX_CNT) ? MAX_CNT : bit_count;
  assign base = cmd.pop ? rd_ptr_r : wr_ptr_r;

  // Ring positions touched by this request, one per field bit
  always_comb begin
    for (int i = 0; i < MAX_FIELD_BITS; i++) begin
      idx[i] = wrap_ptr(SW'(base) + SW'(i));
    end
  end

  // Gather the bits at the head of the ring
  always_comb begin
    raw = '0;
    for (int i = 0; i < MAX_FIELD_BITS; i++) begin
      raw[i] = ring_r[idx[i]];
    end
    for (int i = 0; i < VW; i++) begin
      raw_rev[VW-1-i] = raw[i];
    end
  end

  // Assemble the popped value
  assign mask    = VW'(((VW+1)'(1) << cnt) - (VW+1)'(1));
  assign pop_val = cmd.msb_first ? (raw_rev >> (CW'(VW) - cnt)) : (raw & mask);

  // Order the pushed bits: bit i goes to ring position i after the write pointer
  assign src_shl = push_value << (CW'(VW) - cnt);
  always_comb begin
    for (int i = 0; i < VW; i++) begin
      src_msb[i] = src_shl[VW-1-i];
    end
  end
  assign src = cmd.msb_first ? src_msb : push_value;

  // Scatter pushed bits into the ring; a later bit wins on a repeated cell
  always_comb begin
    ring_nxt = ring_r;
    if (cmd.load && !cmd.pop) begin
      for (int i = 0; i < MAX_FIELD_BITS; i++) begin
        if (CW'(i) < cnt) ring_nxt[idx[i]] = src[i];
      end
    end
  end

  // Advance pointers and shift popped values
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    last_nxt   = last_r;
    prior_nxt  = prior_r;
    if (cmd.load) begin
      if (cmd.pop) begin
        rd_ptr_nxt = wrap_ptr(SW'(rd_ptr_r) + SW'(cnt));
        last_nxt   = pop_val;
        prior_nxt  = last_r;
      end else begin
        wr_ptr_nxt = wrap_ptr(SW'(wr_ptr_r) + SW'(cnt));
      end
    end
  end

  // Fill level from the next pointers
  always_comb begin
    if (wr_ptr_nxt >= rd_ptr_nxt) begin
      diff = (PW+1)'(wr_ptr_nxt) - (PW+1)'(rd_ptr_nxt);
    end else begin
      diff = (PW+1)'(wr_ptr_nxt) + (PW+1)'(RING_BITS) - (PW+1)'(rd_ptr_nxt);
    end
    fill_nxt = CW'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r   <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      last_r   <= '0;
      prior_r  <= '0;
      fill_r   <= '0;
    end else begin
      ring_r   <= ring_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      last_r   <= last_nxt;
      prior_r  <= prior_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign popped_value   = last_r;
  assign previous_value = prior_r;
  assign fill_level     = fill_r;

  // Pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_ptr_r < PW'(RING_BITS - 1) || rd_ptr_r == PW'(RING_BITS - 1)) &&
    (wr_ptr_r < PW'(RING_BITS - 1) || wr_ptr_r == PW'(RING_BITS - 1)))
    else $error("ring pointer out of range");

  // A push leaves the read side untouched
  a_push_keeps_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && !cmd.pop |=> $stable(rd_ptr_r) && $stable(last_r) && $stable(prior_r))
    else $error("push disturbed read side");

  // A pop retires the current value into the previous one
  a_pop_shifts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && cmd.pop |=> prior_r == $past(last_r) && $stable(wr_ptr_r))
    else $error("pop did not shift popped values");

  // Without a request the ring holds
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load |=> $stable(ring_r) && $stable(fill_r))
    else $error("ring changed without a request");

endmodule

`default_nettype wire

// File: sv/bit_ring_fifo_variable_width.sv
// Variable-width bit ring FIFO: push or pop 0 to MAX_FIELD_BITS bits per beat.
// A result beat is offered in the cycle after its request beat is taken.
// One request per cycle; the combinational funnel gather/scatter over
// the ring register sets this, and a stalled result holds off the next request.
// Reset (rst_n low, synchronous): ring bits, pointers, fill level and both
// popped values clear to zero; no result is offered.
`default_nettype none

module bit_ring_fifo_variable_width #(
  parameter int RING_BITS      = 64,
  parameter int MAX_FIELD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [brfvw_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [brfvw_pkg::VALUE_W-1:0] in_push_value,
  input  wire logic [brfvw_pkg::COUNT_W-1:0] in_bit_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [brfvw_pkg::VALUE_W-1:0] out_popped_value,
  output logic      [brfvw_pkg::VALUE_W-1:0] out_previous_value,
  output logic      [brfvw_pkg::FILL_W-1:0]  out_fill_level
);

  brfvw_pkg::cmd_t cmd;

  // Handshake control and request decode
  brfvw_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd)
  );

  // Ring storage and bit movement
  brfvw_dp #(
    .RING_BITS      (RING_BITS),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .push_value     (in_push_value),
    .bit_count      (in_bit_count),
    .popped_value   (out_popped_value),
    .previous_value (out_previous_value),
    .fill_level     (out_fill_level)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the variable-width bit ring FIFO.
// Drives push/pop requests, predicts each result beat and checks it field by field.
// Depends on brfvw_pkg and bit_ring_fifo_variable_width.
`timescale 1ns / 100ps

module testbench;

  localparam int RING_BITS      = 64;
  localparam int MAX_FIELD_BITS = 32;
  localparam int VALUE_W        = brfvw_pkg::VALUE_W;
  localparam int COUNT_W        = brfvw_pkg::COUNT_W;
  localparam int FILL_W         = brfvw_pkg::FILL_W;
  localparam int REQ_W          = brfvw_pkg::REQ_W;

  typedef struct {
    logic [VALUE_W-1:0] popped;
    logic [VALUE_W-1:0] previous;
    logic [FILL_W-1:0]  fill;
  } ring_status_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [REQ_W-1:0]   in_req_type;
  logic [VALUE_W-1:0] in_push_value;
  logic [COUNT_W-1:0] in_bit_count;
  logic               out_valid;
  logic               out_ready;
  logic [VALUE_W-1:0] out_popped_value;
  logic [VALUE_W-1:0] out_previous_value;
  logic [FILL_W-1:0]  out_fill_level;

  // Shadow copy of the ring state
  logic [RING_BITS-1:0] shadow_ring;
  logic [5:0]           shadow_rd;
  logic [5:0]           shadow_wr;
  logic [VALUE_W-1:0]   shadow_last;
  logic [VALUE_W-1:0]   shadow_prior;

  ring_status_t expected_status[$];

  int  errors;
  int  push_beats;
  int  pop_beats;
  int  result_beats;
  bit  send_idle_en;
  bit  recv_stall_en;

  bit_ring_fifo_variable_width #(
    .RING_BITS      (RING_BITS),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_push_value      (in_push_value),
    .in_bit_count       (in_bit_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_popped_value   (out_popped_value),
    .out_previous_value (out_previous_value),
    .out_fill_level     (out_fill_level)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Apply one accepted request to the shadow ring and queue the status it yields
  task automatic ring_apply_request(input logic [REQ_W-1:0] kind,
                                    input logic [VALUE_W-1:0] value,
                                    input logic [COUNT_W-1:0] count);
    int           n;
    int           sh;
    logic [31:0]  acc;
    ring_status_t st;
    n   = (count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(count);
    acc = '0;
    if (kind == brfvw_pkg::REQ_PUSH_MSB || kind == brfvw_pkg::REQ_PUSH_LSB) begin
      for (int i = 0; i < n; i++) begin
        sh = (kind == brfvw_pkg::REQ_PUSH_MSB) ? (n - 1 - i) : i;
        shadow_ring[shadow_wr] = value[sh];
        shadow_wr = shadow_wr + 6'd1;
      end
      push_beats++;
    end else begin
      for (int i = 0; i < n; i++) begin
        sh = (kind == brfvw_pkg::REQ_POP_MSB) ? (n - 1 - i) : i;
        acc[sh] = shadow_ring[shadow_rd];
        shadow_rd = shadow_rd + 6'd1;
      end
      shadow_prior = shadow_last;
      shadow_last  = acc;
      pop_beats++;
    end
    st.popped   = shadow_last;
    st.previous = shadow_prior;
    st.fill     = shadow_wr - shadow_rd;
    expected_status.push_back(st);
  endtask

  // Send one request beat; caller stands at a falling edge
  task automatic send_req(input logic [REQ_W-1:0] kind,
                          input logic [VALUE_W-1:0] value,
                          input logic [COUNT_W-1:0] count);
    if (send_idle_en && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 15)) @(negedge clk);
    in_valid      = 1'b1;
    in_req_type   = kind;
    in_push_value = value;
    in_bit_count  = count;
    do @(posedge clk); while (!in_ready);
    ring_apply_request(kind, value, count);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Counts biased toward the edges: zero, full field, oversized
  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COUNT_W'(MAX_FIELD_BITS);
      2:       return COUNT_W'($urandom_range(MAX_FIELD_BITS + 1, 63));
      default: return COUNT_W'($urandom_range(1, MAX_FIELD_BITS - 1));
    endcase
  endfunction

  // Result stall bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (recv_stall_en && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    ring_status_t st;
    if (rst_n && out_valid && out_ready) begin
      result_beats++;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result beat popped=%h previous=%h fill=%0d", $time,
                 out_popped_value, out_previous_value, out_fill_level);
        errors++;
      end else begin
        st = expected_status.pop_front();
        if (out_popped_value !== st.popped) begin
          $display("%0t: popped_value expected %h actual %h", $time, st.popped,
                   out_popped_value);
          errors++;
        end
        if (out_previous_value !== st.previous) begin
          $display("%0t: previous_value expected %h actual %h", $time, st.previous,
                   out_previous_value);
          errors++;
        end
        if (out_fill_level !== st.fill) begin
          $display("%0t: fill_level expected %0d actual %0d", $time, st.fill,
                   out_fill_level);
          errors++;
        end
      end
    end
  end

  // Edge cases: zero and oversized counts, full ring, overrun, underrun
  task automatic test_directed();
    send_req(brfvw_pkg::REQ_POP_MSB,  32'h0000_0000, 6'd0);
    send_req(brfvw_pkg::REQ_PUSH_MSB, 32'hFFFF_FFA5, 6'd8);
    send_req(brfvw_pkg::REQ_PUSH_LSB, 32'h0000_003C, 6'd8);
    send_req(brfvw_pkg::REQ_POP_MSB,  32'hFFFF_FFFF, 6'd8);
    send_req(brfvw_pkg::REQ_POP_LSB,  32'h0000_0000, 6'd8);
    send_req(brfvw_pkg::REQ_PUSH_MSB, 32'hFFFF_FFFF, 6'd32);
    send_req(brfvw_pkg::REQ_PUSH_LSB, 32'h0000_0000, 6'd32);
    send_req(brfvw_pkg::REQ_PUSH_LSB, 32'hFFFF_FFFF, 6'd5);
    send_req(brfvw_pkg::REQ_POP_LSB,  32'h0000_0000, 6'd32);
    send_req(brfvw_pkg::REQ_POP_MSB,  32'h0000_0000, 6'd32);
    send_req(brfvw_pkg::REQ_POP_MSB,  32'h0000_0000, 6'd40);
    send_req(brfvw_pkg::REQ_PUSH_MSB, 32'hDEAD_BEEF, 6'd63);
    send_req(brfvw_pkg::REQ_PUSH_LSB, 32'hFFFF_FFFF, 6'd0);
    send_req(brfvw_pkg::REQ_POP_LSB,  32'hFFFF_FFFF, 6'd0);
    send_req(brfvw_pkg::REQ_POP_MSB,  32'h0000_0000, 6'd1);
    send_req(brfvw_pkg::REQ_PUSH_MSB, 32'h0000_0001, 6'd1);
    send_req(brfvw_pkg::REQ_POP_LSB,  32'h0000_0000, 6'd63);
    send_req(brfvw_pkg::REQ_PUSH_LSB, 32'hA5A5_5A5A, 6'd32);
    send_req(brfvw_pkg::REQ_PUSH_MSB, 32'h1234_5678, 6'd33);
    send_req(brfvw_pkg::REQ_POP_LSB,  32'h0000_0000, 6'd1);
    send_req(brfvw_pkg::REQ_POP_MSB,  32'h0000_0000, 6'd31);
    send_req(brfvw_pkg::REQ_POP_LSB,  32'h0000_0000, 6'd32);
  endtask

  // Fully random mix of all four request types
  task automatic test_random_mix(input int n);
    repeat (n)
      send_req(REQ_W'($urandom_range(0, 3)), $urandom(), pick_count());
  endtask

  // Alternate push-heavy and pop-heavy phases to wrap, overrun and underrun
  task automatic test_push_pop_bursts(input int n);
    int sent;
    int len;
    bit pushing;
    sent    = 0;
    pushing = 1'b1;
    while (sent < n) begin
      len = $urandom_range(2, 12);
      repeat (len) begin
        if ($urandom_range(0, 7) == 0)
          send_req(REQ_W'($urandom_range(0, 3)), $urandom(), pick_count());
        else if (pushing)
          send_req($urandom_range(0, 1) ? brfvw_pkg::REQ_PUSH_LSB : brfvw_pkg::REQ_PUSH_MSB,
                   $urandom(), pick_count());
        else
          send_req($urandom_range(0, 1) ? brfvw_pkg::REQ_POP_LSB : brfvw_pkg::REQ_POP_MSB,
                   $urandom(), pick_count());
        sent++;
      end
      pushing = ~pushing;
    end
  endtask

  // Back-to-back traffic with both sides always ready
  task automatic test_streaming(input int n);
    send_idle_en  = 1'b0;
    recv_stall_en = 1'b0;
    test_random_mix(n);
  endtask

  // Main sequence
  initial begin
    int waited;
    errors        = 0;
    push_beats    = 0;
    pop_beats     = 0;
    result_beats  = 0;
    send_idle_en  = 1'b1;
    recv_stall_en = 1'b1;
    shadow_ring   = '0;
    shadow_rd     = '0;
    shadow_wr     = '0;
    shadow_last   = '0;
    shadow_prior  = '0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = brfvw_pkg::REQ_PUSH_MSB;
    in_push_value = '0;
    in_bit_count  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_mix(700);
    test_push_pop_bursts(500);
    test_streaming(300);

    // Drain outstanding results
    waited = 0;
    while (expected_status.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_status.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time,
               expected_status.size());
      errors++;
    end
    repeat (5) @(posedge clk);

    $display("Covered %0d push and %0d pop beats, %0d result beats checked,",
             push_beats, pop_beats, result_beats);
    $display("including zero, oversized, overrun, underrun and full-ring cases.");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
